### rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int COUNT_W   = 5;

    localparam logic [DATA_W-1:0] NONE_DATA = {DATA_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_BACK  = 3'd0,
        K_PUSH_FRONT = 3'd1,
        K_POP_BACK   = 3'd2,
        K_POP_FRONT  = 3'd3,
        K_FORWARD    = 3'd4,
        K_BACKWARD   = 3'd5,
        K_READ       = 3'd6
    } t_kind;

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } t_state;

    // What one operation does to the slot memory and how it reports.
    typedef struct packed {
        logic rd;
        logic wr;
        logic found;
        logic dropped;
    } t_mem_op;

endpackage

`default_nettype wire

### rtl/deque_with_cursor_unit.sv
`default_nettype none

// Double-ended queue of signed 32-bit words in a circular slot memory, with a cursor.
// Input channel (i_in_valid / o_in_ready) carries i_kind and i_value; every
// accepted word produces exactly one result word on the output channel
// (o_out_valid / i_out_ready) with o_data, o_found, o_dropped, o_count and
// o_cursor_ok. The pointers are updated at acceptance, and the slot memory is
// written or read in the same cycle.
// Result path: the slot memory registers the word read at the address, and the
// result then enters the output register, from which it is presented.
// Throughput: one word per cycle while the output side keeps up; the next word
// is taken in the cycle the previous result enters the output register.
// If the receiver stalls, one result waits in the output register and one
// item may be pending behind it; input ready then stays low.
// The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets ring
// mode and is always ready; write it only while the block is idle.
// Synchronous reset empties the queue, invalidates the cursor and clears ring
// mode; slot contents are not cleared and need no clearing pass.
module deque_with_cursor_unit #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic                               i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic        [deq_pkg::KIND_W-1:0]  i_kind,
    input  wire logic signed [deq_pkg::DATA_W-1:0]  i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed      [deq_pkg::DATA_W-1:0]  o_data,
    output logic                                    o_found,
    output logic                                    o_dropped,
    output logic             [deq_pkg::COUNT_W-1:0] o_count,
    output logic                                    o_cursor_ok
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::t_state  r_state, n_state;
    deq_pkg::t_mem_op w_op;

    logic                        r_ring;
    logic                        r_out_valid;
    logic [deq_pkg::DATA_W-1:0]  r_data;
    logic                        r_found;
    logic                        r_dropped;
    logic [deq_pkg::COUNT_W-1:0] r_count_out;
    logic                        r_cursor_out;
    logic                        r_pend_found;
    logic                        r_pend_dropped;

    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_out_load;
    logic [PW-1:0]               w_addr;
    logic [CW-1:0]               w_count;
    logic [CW+deq_pkg::COUNT_W-1:0] w_count_ext;
    logic                        w_cursor_ok;
    logic [deq_pkg::DATA_W-1:0]  w_rd_data;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = deq_pkg::S_RESULT;
                end
            end
            deq_pkg::S_RESULT: begin
                if (w_out_free && !w_accept) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            deq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            deq_pkg::S_RESULT: begin
                // The pending result leaves for the output register, so the
                // next word may be taken in the same cycle.
                o_in_ready = w_out_free;
                w_out_load = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
    end

    deq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_kind      (i_kind),
        .i_ring_mode (r_ring),
        .o_op        (w_op),
        .o_addr      (w_addr),
        .o_count     (w_count),
        .o_cursor_ok (w_cursor_ok)
    );

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && w_op.wr),
        .i_rd_en   (w_accept && w_op.rd),
        .i_addr    (w_addr),
        .i_wr_data (i_value),
        .o_rd_data (w_rd_data)
    );

    assign w_count_ext = {{deq_pkg::COUNT_W{1'b0}}, w_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_ring      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_ring <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The pointer registers already hold the state after the pending item.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_found   <= w_op.found;
            r_pend_dropped <= w_op.dropped;
        end
        if (w_out_load) begin
            r_data       <= r_pend_found ? w_rd_data : deq_pkg::NONE_DATA;
            r_found      <= r_pend_found;
            r_dropped    <= r_pend_dropped;
            r_count_out  <= w_count_ext[deq_pkg::COUNT_W-1:0];
            r_cursor_out <= w_cursor_ok;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_data      = r_data;
    assign o_found     = r_found;
    assign o_dropped   = r_dropped;
    assign o_count     = r_count_out;
    assign o_cursor_ok = r_cursor_out;

endmodule

`default_nettype wire

### rtl/deq_ram.sv
`default_nettype none

module deq_ram #(
    parameter int WIDTH = deq_pkg::DATA_W,
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        // The read word is held until the next read is issued.
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/deq_ptr.sv
`default_nettype none

module deq_ptr #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [deq_pkg::KIND_W-1:0]    i_kind,
    input  wire logic                          i_ring_mode,
    output deq_pkg::t_mem_op                   o_op,
    output logic      [$clog2(DEPTH)-1:0]      o_addr,
    output logic      [$clog2(DEPTH+1)-1:0]    o_count,
    output logic                               o_cursor_ok
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW:0]   DEPTH_S = (CW+1)'(DEPTH);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [CW-1:0] ONE = CW'(1);

    logic [PW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_cur, n_cur;
    logic          r_cv, n_cv;

    logic [CW:0]   w_sum;
    logic [PW-1:0] w_tail;
    logic [PW-1:0] w_back;
    logic [PW-1:0] w_front_up;
    logic [PW-1:0] w_front_dn;
    logic          w_empty;

    function automatic logic [PW-1:0] slot_up(input logic [PW-1:0] s);
        return (s == LAST) ? '0 : s + PW'(1);
    endfunction

    function automatic logic [PW-1:0] slot_dn(input logic [PW-1:0] s);
        return (s == '0) ? LAST : s - PW'(1);
    endfunction

    // Slot just past the back entry; the sum stays below twice the depth.
    assign w_sum      = (CW+1)'(r_front) + (CW+1)'(r_count);
    assign w_tail     = (w_sum >= DEPTH_S) ? PW'(w_sum - DEPTH_S) : PW'(w_sum);
    assign w_back     = slot_dn(w_tail);
    assign w_front_up = slot_up(r_front);
    assign w_front_dn = slot_dn(r_front);
    assign w_empty    = (r_count == '0);

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_cur   = r_cur;
        n_cv    = r_cv;
        o_op    = '0;
        o_addr  = r_front;
        case (i_kind)
            deq_pkg::K_PUSH_BACK, deq_pkg::K_PUSH_FRONT: begin
                if (r_count == FULL) begin
                    o_op.dropped = 1'b1;
                end else begin
                    o_op.wr = 1'b1;
                    n_count = r_count + ONE;
                    if (w_empty) begin
                        o_addr = r_front;
                        n_cur  = r_front;
                        n_cv   = 1'b1;
                    end else if (i_kind == deq_pkg::K_PUSH_BACK) begin
                        o_addr = w_tail;
                    end else begin
                        o_addr  = w_front_dn;
                        n_front = w_front_dn;
                    end
                end
            end
            deq_pkg::K_POP_BACK: begin
                if (!w_empty) begin
                    o_op.rd    = 1'b1;
                    o_op.found = 1'b1;
                    o_addr     = w_back;
                    n_count    = r_count - ONE;
                    if (r_cv && r_cur == w_back) begin
                        if (r_count == ONE) begin
                            n_cv = 1'b0;
                        end else begin
                            n_cur = slot_dn(w_back);
                        end
                    end
                end
            end
            deq_pkg::K_POP_FRONT: begin
                if (!w_empty) begin
                    o_op.rd    = 1'b1;
                    o_op.found = 1'b1;
                    o_addr     = r_front;
                    n_count    = r_count - ONE;
                    n_front    = w_front_up;
                    if (r_cv && r_cur == r_front) begin
                        if (r_count == ONE) begin
                            n_cv = 1'b0;
                        end else begin
                            n_cur = w_front_up;
                        end
                    end
                end
            end
            deq_pkg::K_FORWARD: begin
                if (r_cv && !w_empty) begin
                    if (r_cur == w_back) begin
                        if (i_ring_mode) begin
                            n_cur = r_front;
                        end else begin
                            n_cv = 1'b0;
                        end
                    end else begin
                        n_cur = slot_up(r_cur);
                    end
                end
            end
            deq_pkg::K_BACKWARD: begin
                if (r_cv && !w_empty) begin
                    if (r_cur == r_front) begin
                        if (i_ring_mode) begin
                            n_cur = w_back;
                        end else begin
                            n_cv = 1'b0;
                        end
                    end else begin
                        n_cur = slot_dn(r_cur);
                    end
                end
            end
            deq_pkg::K_READ: begin
                if (r_cv && !w_empty) begin
                    o_op.rd    = 1'b1;
                    o_op.found = 1'b1;
                    o_addr     = r_cur;
                end
            end
            default: begin
                o_op = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_cur   <= '0;
            r_cv    <= 1'b0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_cv    <= n_cv;
        end
    end

    assign o_count     = r_count;
    assign o_cursor_ok = r_cv;

endmodule

`default_nettype wire

### dv/tb_deque_with_cursor_unit.sv
`timescale 1ns / 100ps

module tb_deque_with_cursor_unit;

    localparam int DEPTH      = deq_pkg::DEPTH_DEF;
    localparam int DATA_W     = deq_pkg::DATA_W;
    localparam int KIND_W     = deq_pkg::KIND_W;
    localparam int COUNT_W    = deq_pkg::COUNT_W;
    localparam logic [DATA_W-1:0] NONE_DATA = deq_pkg::NONE_DATA;
    localparam int CYCLE_CAP  = 300000;
    localparam int LONG_HOLD  = 300;
    localparam int PHASE_LEN  = 375;
    localparam int N_PHASES   = 4;

    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        logic                      found;
        logic                      dropped;
        logic        [COUNT_W-1:0] count;
        logic                      cursor_ok;
    } t_deq_result;

    typedef struct packed {
        logic               cfg_wr;
        logic               cfg_ring;
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  value;
        int                 reps;
        logic               known;
        t_deq_result        res;
    } t_dir_row;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_op_mix;
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_pace;

    localparam t_deq_result NOTHING_RES = '{NONE_DATA, 1'b0, 1'b0, 5'd0, 1'b0};
    localparam t_deq_result UNTYPED     = '0;

    localparam int N_DIR = 29;

    // Rows with known set carry their result; the rest go to the predictor.
    t_dir_row dir_tab [N_DIR] = '{
        '{1'b0, 1'b0, deq_pkg::K_READ,       32'h0,        1,  1'b1, NOTHING_RES},
        '{1'b0, 1'b0, deq_pkg::K_POP_BACK,   32'h0,        1,  1'b1, NOTHING_RES},
        '{1'b0, 1'b0, deq_pkg::K_POP_FRONT,  32'h0,        1,  1'b1, NOTHING_RES},
        '{1'b0, 1'b0, deq_pkg::K_FORWARD,    32'h0,        1,  1'b1, NOTHING_RES},
        '{1'b0, 1'b0, deq_pkg::K_BACKWARD,   32'h0,        1,  1'b1, NOTHING_RES},
        '{1'b0, 1'b0, KIND_SPARE,            32'h1234_5678, 1, 1'b1, NOTHING_RES},
        '{1'b0, 1'b0, deq_pkg::K_PUSH_BACK,  32'h7FFF_FFFF, 1, 1'b1,
          '{NONE_DATA, 1'b0, 1'b0, 5'd1, 1'b1}},
        '{1'b0, 1'b0, deq_pkg::K_READ,       32'h0,        1,  1'b1,
          '{32'sh7FFF_FFFF, 1'b1, 1'b0, 5'd1, 1'b1}},
        '{1'b0, 1'b0, deq_pkg::K_PUSH_FRONT, 32'h8000_0000, 1, 1'b1,
          '{NONE_DATA, 1'b0, 1'b0, 5'd2, 1'b1}},
        '{1'b0, 1'b0, deq_pkg::K_READ,       32'h0,        1,  1'b1,
          '{32'sh7FFF_FFFF, 1'b1, 1'b0, 5'd2, 1'b1}},
        '{1'b0, 1'b0, deq_pkg::K_BACKWARD,   32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_POP_FRONT,  32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_READ,       32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_FORWARD,    32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_READ,       32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_FORWARD,    32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_PUSH_BACK,  32'h10,       15, 1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_PUSH_FRONT, 32'h5555_5555, 1, 1'b1,
          '{NONE_DATA, 1'b0, 1'b1, 5'd16, 1'b0}},
        '{1'b0, 1'b0, deq_pkg::K_POP_BACK,   32'h0,        16, 1'b0, UNTYPED},
        '{1'b1, 1'b1, deq_pkg::K_PUSH_FRONT, 32'h1,        1,  1'b1,
          '{NONE_DATA, 1'b0, 1'b0, 5'd1, 1'b1}},
        '{1'b0, 1'b0, deq_pkg::K_FORWARD,    32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_BACKWARD,   32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_PUSH_BACK,  32'h2,        2,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_BACKWARD,   32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_READ,       32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_FORWARD,    32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_BACKWARD,   32'h0,        1,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_POP_BACK,   32'h0,        2,  1'b0, UNTYPED},
        '{1'b0, 1'b0, deq_pkg::K_POP_FRONT,  32'h0,        1,  1'b0, UNTYPED}
    };

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic                      i_cfg_data  = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    logic        [KIND_W-1:0]  i_kind      = '0;
    logic signed [DATA_W-1:0]  i_value     = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [DATA_W-1:0]  o_data;
    logic                      o_found;
    logic                      o_dropped;
    logic        [COUNT_W-1:0] o_count;
    logic                      o_cursor_ok;

    // Travels with the word on the input channel, so it is sampled with it.
    logic        word_known = 1'b0;
    t_deq_result word_res   = '0;

    deque_with_cursor_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_data),
        .o_found     (o_found),
        .o_dropped   (o_dropped),
        .o_count     (o_count),
        .o_cursor_ok (o_cursor_ok)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the queue, kept in step with every accepted word.
    logic [DATA_W-1:0] mirror_slots [DEPTH];
    int                mirror_front     = 0;
    int                mirror_held      = 0;
    int                mirror_cursor    = 0;
    logic              mirror_cursor_ok = 1'b0;
    logic              mirror_ring      = 1'b0;

    t_deq_result pending_results [$];

    int  n_err        = 0;
    int  n_words      = 0;
    int  n_ring_words = 0;
    int  n_checked    = 0;
    int  n_found      = 0;
    int  n_drops      = 0;
    int  n_cycles     = 0;
    int  burst_left   = 0;
    logic hold_armed  = 1'b0;

    function automatic t_deq_result apply_op(input logic [KIND_W-1:0] kind,
                                             input logic [DATA_W-1:0] value);
        t_deq_result r;
        int          back;
        int          was;
        r      = '{NONE_DATA, 1'b0, 1'b0, 5'd0, 1'b0};
        back   = (mirror_front + mirror_held + DEPTH - 1) % DEPTH;
        case (kind)
            deq_pkg::K_PUSH_BACK, deq_pkg::K_PUSH_FRONT: begin
                if (mirror_held >= DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    if (mirror_held == 0) begin
                        mirror_slots[mirror_front] = value;
                        mirror_cursor    = mirror_front;
                        mirror_cursor_ok = 1'b1;
                    end else if (kind == deq_pkg::K_PUSH_BACK) begin
                        mirror_slots[(mirror_front + mirror_held) % DEPTH] = value;
                    end else begin
                        mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                        mirror_slots[mirror_front] = value;
                    end
                    mirror_held++;
                end
            end
            deq_pkg::K_POP_BACK: begin
                if (mirror_held != 0) begin
                    r.data  = mirror_slots[back];
                    r.found = 1'b1;
                    mirror_held--;
                    if (mirror_cursor_ok && mirror_cursor == back) begin
                        if (mirror_held == 0)
                            mirror_cursor_ok = 1'b0;
                        else
                            mirror_cursor = (back + DEPTH - 1) % DEPTH;
                    end
                end
            end
            deq_pkg::K_POP_FRONT: begin
                if (mirror_held != 0) begin
                    was     = mirror_front;
                    r.data  = mirror_slots[was];
                    r.found = 1'b1;
                    mirror_held--;
                    mirror_front = (was + 1) % DEPTH;
                    if (mirror_cursor_ok && mirror_cursor == was) begin
                        if (mirror_held == 0)
                            mirror_cursor_ok = 1'b0;
                        else
                            mirror_cursor = mirror_front;
                    end
                end
            end
            deq_pkg::K_FORWARD: begin
                if (mirror_cursor_ok && mirror_held != 0) begin
                    if (mirror_cursor == back) begin
                        if (mirror_ring)
                            mirror_cursor = mirror_front;
                        else
                            mirror_cursor_ok = 1'b0;
                    end else begin
                        mirror_cursor = (mirror_cursor + 1) % DEPTH;
                    end
                end
            end
            deq_pkg::K_BACKWARD: begin
                if (mirror_cursor_ok && mirror_held != 0) begin
                    if (mirror_cursor == mirror_front) begin
                        if (mirror_ring)
                            mirror_cursor = back;
                        else
                            mirror_cursor_ok = 1'b0;
                    end else begin
                        mirror_cursor = (mirror_cursor + DEPTH - 1) % DEPTH;
                    end
                end
            end
            deq_pkg::K_READ: begin
                if (mirror_cursor_ok && mirror_held != 0) begin
                    r.data  = mirror_slots[mirror_cursor];
                    r.found = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count     = mirror_held[COUNT_W-1:0];
        r.cursor_ok = mirror_cursor_ok;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 'h%h, got 'h%h", $time, name, want, got);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_deq_result want;
        t_deq_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                mirror_ring = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                want = apply_op(i_kind, i_value);
                if (word_known)
                    want = word_res;
                pending_results.insert(pending_results.size(), want);
                n_words++;
                if (mirror_ring)
                    n_ring_words++;
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_data, o_found, o_dropped, o_count, o_cursor_ok};
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with nothing expected: data 'h%h count %0d",
                             $time, got.data, got.count);
                    n_err++;
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    compare_field("data", want.data, got.data);
                    compare_field("found", want.found, got.found);
                    compare_field("dropped", want.dropped, got.dropped);
                    compare_field("count", want.count, got.count);
                    compare_field("cursor_ok", want.cursor_ok, got.cursor_ok);
                    n_checked++;
                    n_found += got.found;
                    n_drops += got.dropped;
                end
            end
        end
    end

    // Receiver pacing: changing stall patterns, plus one long hold-off once
    // the random part has started, so that the block backs up into its input.
    always @(posedge i_clk) begin : receiver
        static t_rx_pace rx_mode      = RX_OPEN;
        static int       rx_span      = 0;
        static int       rx_hold_left = 0;
        static logic     hold_taken   = 1'b0;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            hold_taken   = 1'b1;
            rx_hold_left = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_mode = t_rx_pace'($urandom_range(0, 3));
                rx_span = $urandom_range(16, 128);
            end
            rx_span--;
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:   i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_CAP) begin
            $display("%0t: run stopped at the cycle limit, %0d results still owed",
                     $time, pending_results.size());
            $display("tb_deque_with_cursor_unit: errors");
            $finish;
        end
    end

    // Offers one word and holds it until taken; between bursts the sender
    // drops valid for a random gap.
    task automatic offer_word(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                              input logic known, input t_deq_result res);
        int gap;
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_value    <= value;
        word_known <= known;
        word_res   <= res;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_ring(input logic ring);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ring;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_op_mix           mix;
        int                mix_left;
        int                pick;
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] value;
        mix_left = 0;
        mix      = MIX_EVEN;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_tab[r].cfg_wr)
                set_ring(dir_tab[r].cfg_ring);
            for (int k = 0; k < dir_tab[r].reps; k++)
                offer_word(dir_tab[r].kind, dir_tab[r].value + k, dir_tab[r].known,
                           dir_tab[r].res);
        end

        // Random part: runs of push-heavy, pop-heavy and even traffic so the
        // queue keeps swinging between empty and full, in both cursor modes.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_ring(ph[0]);
            hold_armed = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (mix_left == 0) begin
                    mix      = t_op_mix'($urandom_range(0, 2));
                    mix_left = $urandom_range(10, 60);
                end
                mix_left--;
                pick = $urandom_range(0, 99);
                if (pick < ((mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 15 : 30))
                    kind = $urandom_range(0, 1) ? deq_pkg::K_PUSH_FRONT
                                                : deq_pkg::K_PUSH_BACK;
                else if (pick < 75)
                    kind = $urandom_range(0, 1) ? deq_pkg::K_POP_FRONT
                                                : deq_pkg::K_POP_BACK;
                else if (pick < 83)
                    kind = deq_pkg::K_FORWARD;
                else if (pick < 91)
                    kind = deq_pkg::K_BACKWARD;
                else if (pick < 98)
                    kind = deq_pkg::K_READ;
                else
                    kind = KIND_SPARE;
                case ($urandom_range(0, 7))
                    0:       value = 32'h7FFF_FFFF;
                    1:       value = 32'h8000_0000;
                    2:       value = '1;
                    3:       value = '0;
                    default: value = $urandom;
                endcase
                offer_word(kind, value, 1'b0, UNTYPED);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("%0d words offered (%0d in ring mode), %0d results checked", n_words,
                 n_ring_words, n_checked);
        $display("%0d results carried a stored value, %0d pushes refused on a full queue",
                 n_found, n_drops);
        if (n_err == 0)
            $display("tb_deque_with_cursor_unit: clean");
        else
            $display("tb_deque_with_cursor_unit: errors");
        $finish;
    end

endmodule

### files.f
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ptr.sv
rtl/deque_with_cursor_unit.sv
dv/tb_deque_with_cursor_unit.sv
